// ===== rtl/core/imrot_pkg.sv =====
// Shared constants and types of the bilinear image rotation block.
package imrot_pkg;

  localparam int ROWS_MAX  = 256;
  localparam int COLS_MAX  = 256;
  localparam int FRAC_BITS = 14;

  localparam int ROW_W   = $clog2(ROWS_MAX);
  localparam int COL_W   = $clog2(COLS_MAX);
  localparam int SIZE_W  = 9;
  localparam int TRIG_W  = 16;
  localparam int PIX_W   = 8;
  localparam int BANK_AW = ROW_W - 1 + COL_W - 1;
  localparam int WGT_W   = FRAC_BITS + 1;

  localparam logic [2:0] CFG_ROWS = 3'd0;
  localparam logic [2:0] CFG_COLS = 3'd1;
  localparam logic [2:0] CFG_COS  = 3'd2;
  localparam logic [2:0] CFG_SIN  = 3'd3;
  localparam logic [2:0] CFG_MODE = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0]        nr;
    logic [SIZE_W-1:0]        nc;
    logic signed [TRIG_W-1:0] cos_a;
    logic signed [TRIG_W-1:0] sin_a;
    logic                     bilinear;
  } imrot_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_load;
    logic [7:0]           row;
    logic [7:0]           col;
    logic [PIX_W-1:0]     pix;
    logic [ROW_W-1:0]     x0;
    logic [ROW_W-1:0]     x1;
    logic [COL_W-1:0]     y0;
    logic [COL_W-1:0]     y1;
    logic [FRAC_BITS-1:0] l;
    logic [FRAC_BITS-1:0] m;
  } imrot_item_t;

  typedef struct packed {
    logic                 valid;
    logic [7:0]           row;
    logic [7:0]           col;
    logic [PIX_W-1:0]     s00;
    logic [PIX_W-1:0]     s01;
    logic [PIX_W-1:0]     s10;
    logic [PIX_W-1:0]     s11;
    logic [FRAC_BITS-1:0] l;
    logic [FRAC_BITS-1:0] m;
  } imrot_samp_t;

endpackage

// ===== rtl/core/image_rotate_bilinear_unit.sv =====
// Top level of the bilinear image rotation block.
//
// Input beats are taken on start while busy is low; busy never rises, so one
// beat can be taken every cycle. in_cmd low loads in_pixel_in at (in_row,
// in_col) into the pixel store; in_cmd high requests the rotated pixel at
// (in_row, in_col), sampled from the store by bilinear or nearest mapping.
// A request gives one result beat on out_valid, out_row, out_col, out_pixel,
// held for exactly one cycle, after six coordinate mapping stages, one store
// read and three blending and rounding stages. Loads give no result.
// Throughput is one beat a cycle, set by four parity banks of the store that
// each give one read or write per cycle. The receiver cannot stall; every
// result is taken as it appears. The user must write configuration through
// cfg_we, cfg_index and cfg_wdata only while no request is in flight; the
// block does not enforce this. Reset clears the pipeline and sets the
// registers to 256 rows, 256 columns, no rotation and bilinear mode; the
// store content is undefined until loaded and reset does not sweep it.
module image_rotate_bilinear_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  output logic [7:0]  out_row,
  output logic [7:0]  out_col,
  output logic [7:0]  out_pixel,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [imrot_pkg::SIZE_W-1:0] rows_r, cols_r;
  logic [imrot_pkg::TRIG_W-1:0] cos_r, sin_r;
  logic mode_r;
  logic [imrot_pkg::SIZE_W-1:0] nr, nc;
  imrot_pkg::imrot_cfg_t  cfg;
  imrot_pkg::imrot_item_t item;
  imrot_pkg::imrot_samp_t samp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= imrot_pkg::SIZE_W'(256);
      cols_r <= imrot_pkg::SIZE_W'(256);
      cos_r  <= 16'd16384;
      sin_r  <= 16'd0;
      mode_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imrot_pkg::CFG_ROWS: rows_r <= cfg_wdata[imrot_pkg::SIZE_W-1:0];
        imrot_pkg::CFG_COLS: cols_r <= cfg_wdata[imrot_pkg::SIZE_W-1:0];
        imrot_pkg::CFG_COS:  cos_r  <= cfg_wdata;
        imrot_pkg::CFG_SIN:  sin_r  <= cfg_wdata;
        imrot_pkg::CFG_MODE: mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one, and sizes beyond the store act as its limit.
  always_comb begin
    if (rows_r == '0) begin
      nr = imrot_pkg::SIZE_W'(1);
    end else if (rows_r > imrot_pkg::SIZE_W'(imrot_pkg::ROWS_MAX)) begin
      nr = imrot_pkg::SIZE_W'(imrot_pkg::ROWS_MAX);
    end else begin
      nr = rows_r;
    end
    if (cols_r == '0) begin
      nc = imrot_pkg::SIZE_W'(1);
    end else if (cols_r > imrot_pkg::SIZE_W'(imrot_pkg::COLS_MAX)) begin
      nc = imrot_pkg::SIZE_W'(imrot_pkg::COLS_MAX);
    end else begin
      nc = cols_r;
    end
  end

  assign cfg  = '{nr: nr, nc: nc, cos_a: cos_r, sin_a: sin_r, bilinear: mode_r};
  assign busy = 1'b0;

  imrot_map u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start && !busy),
    .in_cmd      (in_cmd),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_pixel_in (in_pixel_in),
    .cfg         (cfg),
    .item_o      (item)
  );

  imrot_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (item),
    .samp_o (samp)
  );

  imrot_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .samp_i    (samp),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_pixel (out_pixel)
  );

endmodule

// ===== rtl/core/imrot_ram.sv =====
// Generic single-port RAM with registered read data.
module imrot_ram #(
  parameter int AW = 14,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/imrot_map.sv =====
// Coordinate pipeline: maps an output pixel to clamped source neighbours and weights.
module imrot_map (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_cmd,
  input  logic [7:0]               in_row,
  input  logic [7:0]               in_col,
  input  logic [7:0]               in_pixel_in,
  input  imrot_pkg::imrot_cfg_t    cfg,
  output imrot_pkg::imrot_item_t   item_o
);

  localparam int D_W   = 11;
  localparam int P_W   = 27;
  localparam int S_W   = 28;
  localparam int IDX_W = S_W - imrot_pkg::FRAC_BITS;
  localparam int SH    = 15 - imrot_pkg::FRAC_BITS;
  localparam logic [S_W-1:0] RMASK  = (S_W'(1) << SH) - S_W'(1);
  localparam logic [S_W-1:0] RHALF  = S_W'(1) << (SH - 1);
  localparam logic [imrot_pkg::FRAC_BITS-1:0] FHALF =
    imrot_pkg::FRAC_BITS'(1) << (imrot_pkg::FRAC_BITS - 1);
  localparam logic signed [S_W-1:0] NHALF = S_W'(1) << (imrot_pkg::FRAC_BITS - 1);

  logic [6:1] vld_r;
  logic       ld_r  [1:6];
  logic [7:0] row_r [1:6];
  logic [7:0] col_r [1:6];
  logic [7:0] pix_r [1:6];

  logic signed [D_W-1:0] di_r, dj_r;
  logic signed [P_W-1:0] pcx_r, psy_r, psx_r, pcy_r;
  logic signed [S_W-1:0] sx_r, sy_r, xf_r, yf_r;
  logic signed [IDX_W-1:0] bx_r, by_r;
  logic [imrot_pkg::FRAC_BITS-1:0] l_r, m_r, l6_r, m6_r;
  logic [imrot_pkg::ROW_W-1:0] x0_r, x1_r;
  logic [imrot_pkg::COL_W-1:0] y0_r, y1_r;

  logic signed [S_W-1:0] xf_nxt, yf_nxt;
  logic signed [IDX_W-1:0] bx_nxt, by_nxt;

  function automatic logic signed [S_W-1:0] rne_frac(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] q;
    logic [S_W-1:0]        r;
    q = v >>> SH;
    r = v & RMASK;
    if (r > RHALF || (r == RHALF && q[0])) begin
      q = q + S_W'(1);
    end
    return q;
  endfunction

  function automatic logic signed [IDX_W-1:0] pick(input logic signed [S_W-1:0] v,
                                                   input logic bil);
    logic signed [S_W-1:0] t;
    logic signed [IDX_W-1:0] q;
    logic [imrot_pkg::FRAC_BITS-1:0] r;
    if (bil) begin
      q = IDX_W'(v >>> imrot_pkg::FRAC_BITS);
    end else begin
      t = v + NHALF;
      q = IDX_W'(t >>> imrot_pkg::FRAC_BITS);
      r = t[imrot_pkg::FRAC_BITS-1:0];
      if (r > FHALF || (r == FHALF && q[0])) begin
        q = q + IDX_W'(1);
      end
    end
    return q;
  endfunction

  function automatic logic [7:0] clampi(input logic signed [IDX_W-1:0] v,
                                        input logic [imrot_pkg::SIZE_W-1:0] n);
    logic signed [IDX_W-1:0] ns;
    logic [imrot_pkg::SIZE_W-1:0] top;
    ns  = $signed(IDX_W'(n));
    top = n - imrot_pkg::SIZE_W'(1);
    if (v < 0) begin
      return 8'd0;
    end else if (v >= ns) begin
      return top[7:0];
    end
    return v[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ld_r[1]  <= !in_cmd;
    row_r[1] <= in_row;
    col_r[1] <= in_col;
    pix_r[1] <= in_pixel_in;
    for (int k = 2; k <= 6; k++) begin
      ld_r[k]  <= ld_r[k-1];
      row_r[k] <= row_r[k-1];
      col_r[k] <= col_r[k-1];
      pix_r[k] <= pix_r[k-1];
    end
  end

  always_comb begin
    xf_nxt = rne_frac(sx_r);
    yf_nxt = rne_frac(sy_r);
    bx_nxt = pick(xf_r, cfg.bilinear);
    by_nxt = pick(yf_r, cfg.bilinear);
  end

  always_ff @(posedge clk) begin
    di_r  <= $signed({2'b00, in_row, 1'b0}) - $signed({2'b00, cfg.nr});
    dj_r  <= $signed({2'b00, in_col, 1'b0}) - $signed({2'b00, cfg.nc});
    pcx_r <= P_W'(cfg.cos_a * di_r);
    psy_r <= P_W'(cfg.sin_a * dj_r);
    psx_r <= P_W'(cfg.sin_a * di_r);
    pcy_r <= P_W'(cfg.cos_a * dj_r);
    // Q2.14 trig times a doubled offset gives 15 fraction bits.
    sx_r  <= S_W'(pcx_r) - S_W'(psy_r) + $signed({5'b0, cfg.nr, 14'b0});
    sy_r  <= S_W'(psx_r) + S_W'(pcy_r) + $signed({5'b0, cfg.nc, 14'b0});
    xf_r  <= xf_nxt;
    yf_r  <= yf_nxt;
    bx_r  <= bx_nxt;
    by_r  <= by_nxt;
    l_r   <= cfg.bilinear ? xf_r[imrot_pkg::FRAC_BITS-1:0] : '0;
    m_r   <= cfg.bilinear ? yf_r[imrot_pkg::FRAC_BITS-1:0] : '0;
    x0_r  <= clampi(bx_r, cfg.nr);
    y0_r  <= clampi(by_r, cfg.nc);
    x1_r  <= cfg.bilinear ? clampi(bx_r + IDX_W'(1), cfg.nr) : clampi(bx_r, cfg.nr);
    y1_r  <= cfg.bilinear ? clampi(by_r + IDX_W'(1), cfg.nc) : clampi(by_r, cfg.nc);
    l6_r  <= l_r;
    m6_r  <= m_r;
  end

  assign item_o = '{valid: vld_r[6], is_load: ld_r[6], row: row_r[6], col: col_r[6],
                    pix: pix_r[6], x0: x0_r, x1: x1_r, y0: y0_r, y1: y1_r,
                    l: l6_r, m: m6_r};

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[6] && !ld_r[6]) |-> ((x1_r == x0_r || x1_r == x0_r + 1'b1) &&
                                (y1_r == y0_r || y1_r == y0_r + 1'b1)))
    else $error("neighbour rows or columns not adjacent");

  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[6] && !ld_r[6]) |-> ({1'b0, x1_r} < cfg.nr && {1'b0, y1_r} < cfg.nc))
    else $error("neighbour outside image");

  a_near: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[6] && !ld_r[6] && !cfg.bilinear) |->
      (l6_r == '0 && m6_r == '0 && x0_r == x1_r && y0_r == y1_r))
    else $error("nearest request carries blend weights");

endmodule

// ===== rtl/core/imrot_store.sv =====
// Pixel store in four parity banks, one read or write of each bank per cycle.
module imrot_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  imrot_pkg::imrot_item_t item_i,
  output imrot_pkg::imrot_samp_t samp_o
);

  logic [imrot_pkg::PIX_W-1:0] rd [4];

  logic vld_r;
  logic [7:0] row_r, col_r;
  logic [imrot_pkg::FRAC_BITS-1:0] l_r, m_r;
  logic x0p_r, x1p_r, y0p_r, y1p_r;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BK = 2'(b);
    logic we;
    logic [imrot_pkg::ROW_W-1:0] rsel;
    logic [imrot_pkg::COL_W-1:0] csel;
    logic [imrot_pkg::BANK_AW-1:0] addr;

    // Each bank serves the one neighbour row and column of its parity.
    always_comb begin
      rsel = (item_i.x0[0] == BK[1]) ? item_i.x0 : item_i.x1;
      csel = (item_i.y0[0] == BK[0]) ? item_i.y0 : item_i.y1;
      we   = item_i.valid && item_i.is_load &&
             item_i.row[0] == BK[1] && item_i.col[0] == BK[0];
      addr = we ? {item_i.row[imrot_pkg::ROW_W-1:1], item_i.col[imrot_pkg::COL_W-1:1]}
                : {rsel[imrot_pkg::ROW_W-1:1], csel[imrot_pkg::COL_W-1:1]};
    end

    imrot_ram #(.AW(imrot_pkg::BANK_AW), .DW(imrot_pkg::PIX_W)) u_ram (
      .clk   (clk),
      .we    (we),
      .addr  (addr),
      .wdata (item_i.pix),
      .rdata (rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= item_i.valid && !item_i.is_load;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= item_i.row;
    col_r <= item_i.col;
    l_r   <= item_i.l;
    m_r   <= item_i.m;
    x0p_r <= item_i.x0[0];
    x1p_r <= item_i.x1[0];
    y0p_r <= item_i.y0[0];
    y1p_r <= item_i.y1[0];
  end

  assign samp_o = '{valid: vld_r, row: row_r, col: col_r,
                    s00: rd[{x0p_r, y0p_r}], s01: rd[{x0p_r, y1p_r}],
                    s10: rd[{x1p_r, y0p_r}], s11: rd[{x1p_r, y1p_r}],
                    l: l_r, m: m_r};

endmodule

// ===== rtl/core/imrot_blend.sv =====
// Bilinear blend of four samples, rounded half to even and clamped.
module imrot_blend (
  input  logic                   clk,
  input  logic                   rst_n,
  input  imrot_pkg::imrot_samp_t samp_i,
  output logic                   out_valid,
  output logic [7:0]             out_row,
  output logic [7:0]             out_col,
  output logic [7:0]             out_pixel
);

  localparam int H_W   = imrot_pkg::WGT_W + imrot_pkg::PIX_W;
  localparam int ACC_W = imrot_pkg::WGT_W + H_W;
  localparam int SH2   = 2 * imrot_pkg::FRAC_BITS;
  localparam int Q_W   = ACC_W - SH2 + 1;
  localparam logic [imrot_pkg::WGT_W-1:0] ONE =
    imrot_pkg::WGT_W'(1) << imrot_pkg::FRAC_BITS;
  localparam logic [SH2-1:0] HALF2 = SH2'(1) << (SH2 - 1);

  logic [1:0] vld_r;
  logic [7:0] row_r [2];
  logic [7:0] col_r [2];
  logic [H_W-1:0] h0_r, h1_r;
  logic [imrot_pkg::WGT_W-1:0] l_r;
  logic [ACC_W-1:0] acc_r;
  logic [Q_W-1:0] q_nxt;
  logic [7:0] pix_nxt;

  logic out_valid_r;
  logic [7:0] out_row_r, out_col_r, out_pixel_r;

  always_comb begin
    q_nxt = Q_W'(acc_r[ACC_W-1:SH2]);
    if (acc_r[SH2-1:0] > HALF2 || (acc_r[SH2-1:0] == HALF2 && q_nxt[0])) begin
      q_nxt = q_nxt + Q_W'(1);
    end
    pix_nxt = (q_nxt > Q_W'(255)) ? 8'd255 : q_nxt[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[0], samp_i.valid};
      out_valid_r <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    row_r[0] <= samp_i.row;
    col_r[0] <= samp_i.col;
    row_r[1] <= row_r[0];
    col_r[1] <= col_r[0];
    h0_r  <= H_W'(ONE - imrot_pkg::WGT_W'(samp_i.m)) * H_W'(samp_i.s00)
           + H_W'(samp_i.m) * H_W'(samp_i.s01);
    h1_r  <= H_W'(ONE - imrot_pkg::WGT_W'(samp_i.m)) * H_W'(samp_i.s10)
           + H_W'(samp_i.m) * H_W'(samp_i.s11);
    l_r   <= imrot_pkg::WGT_W'(samp_i.l);
    acc_r <= ACC_W'(ONE - l_r) * ACC_W'(h0_r) + ACC_W'(l_r) * ACC_W'(h1_r);
    out_row_r   <= row_r[1];
    out_col_r   <= col_r[1];
    out_pixel_r <= pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_pixel = out_pixel_r;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the bilinear image rotation block.
`timescale 1ns / 100ps

module tb;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REQ  = 1'b1;
  localparam logic [2:0] CFG_SPARE = 3'd5;
  localparam int PIPE_CYCLES = 12;

  typedef struct packed {
    logic       cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pix;
  } pixel_op_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pix;
  } rotated_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [7:0]  in_row = '0;
  logic [7:0]  in_col = '0;
  logic [7:0]  in_pixel_in = '0;
  logic        out_valid;
  logic [7:0]  out_row;
  logic [7:0]  out_col;
  logic [7:0]  out_pixel;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  pixel_op_t   pending_ops[$];
  rotated_px_t awaited_px[$];
  logic [7:0]  src_image[imrot_pkg::ROWS_MAX*imrot_pkg::COLS_MAX];
  bit          loaded[imrot_pkg::ROWS_MAX*imrot_pkg::COLS_MAX];
  logic [8:0]  img_rows = 9'd256;
  logic [8:0]  img_cols = 9'd256;
  logic signed [15:0] cos_q = 16'sd16384;
  logic signed [15:0] sin_q = 16'sd0;
  logic        bilinear_on = 1'b1;
  int          idle_pct = 37;
  bit          hold_off = 1'b0;
  int          err_count = 0;
  int          req_count = 0;
  int          load_count = 0;
  int          checked_count = 0;
  int          setting_count = 0;

  image_rotate_bilinear_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic longint rne_shr(input longint v, input int sh);
    longint q, r, half;
    q = v >>> sh;
    r = v - (q <<< sh);
    half = longint'(1) <<< (sh - 1);
    if (r > half || (r == half && q[0])) q++;
    return q;
  endfunction

  function automatic longint clamped_px(input longint x, input longint y,
                                        input longint nr, input longint nc);
    if (x < 0) x = 0;
    else if (x >= nr) x = nr - 1;
    if (y < 0) y = 0;
    else if (y >= nc) y = nc - 1;
    return longint'(src_image[x*imrot_pkg::COLS_MAX + y]);
  endfunction

  function automatic void map_point(input logic [7:0] row, input logic [7:0] col,
                                    output longint nr, output longint nc,
                                    output longint xf, output longint yf);
    longint di, dj;
    nr = (img_rows == 0) ? 1 : (img_rows > imrot_pkg::ROWS_MAX) ? imrot_pkg::ROWS_MAX
                                                                 : longint'(img_rows);
    nc = (img_cols == 0) ? 1 : (img_cols > imrot_pkg::COLS_MAX) ? imrot_pkg::COLS_MAX
                                                                 : longint'(img_cols);
    di = 2*longint'(row) - nr;
    dj = 2*longint'(col) - nc;
    // Products carry one more fraction bit than the coordinate keeps.
    xf = rne_shr(longint'(cos_q)*di - longint'(sin_q)*dj + nr*16384, 1);
    yf = rne_shr(longint'(sin_q)*di + longint'(cos_q)*dj + nc*16384, 1);
  endfunction

  function automatic logic [7:0] rotated_pixel(input logic [7:0] row, input logic [7:0] col);
    longint nr, nc, xf, yf, i, j, l, m, acc, val, one;
    one = longint'(1) <<< imrot_pkg::FRAC_BITS;
    map_point(row, col, nr, nc, xf, yf);
    if (bilinear_on) begin
      i = xf >>> imrot_pkg::FRAC_BITS;
      j = yf >>> imrot_pkg::FRAC_BITS;
      l = xf - i*one;
      m = yf - j*one;
      acc = (one - l)*((one - m)*clamped_px(i, j, nr, nc) + m*clamped_px(i, j+1, nr, nc))
          + l*((one - m)*clamped_px(i+1, j, nr, nc) + m*clamped_px(i+1, j+1, nr, nc));
      val = rne_shr(acc, 2*imrot_pkg::FRAC_BITS);
      if (val > 255) val = 255;
      if (val < 0) val = 0;
    end else begin
      val = clamped_px(rne_shr(xf + one/2, imrot_pkg::FRAC_BITS),
                       rne_shr(yf + one/2, imrot_pkg::FRAC_BITS), nr, nc);
    end
    return val[7:0];
  endfunction

  // Driver: takes the beat offered at this edge, then offers the next one.
  always @(posedge clk) begin
    pixel_op_t op;
    rotated_px_t exp_px;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (in_cmd == CMD_LOAD) begin
          src_image[{in_row, in_col}] = in_pixel_in;
          load_count++;
        end else begin
          exp_px = '{in_row, in_col, rotated_pixel(in_row, in_col)};
          awaited_px = {awaited_px, exp_px};
          req_count++;
        end
      end
      if (!(start && busy)) begin
        if (!hold_off && pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
          op = pending_ops.pop_front();
          start <= 1'b1;
          in_cmd <= op.cmd;
          in_row <= op.row;
          in_col <= op.col;
          in_pixel_in <= op.pix;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rotated_px_t want;
    if (rst_n && out_valid) begin
      if (awaited_px.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d", out_row, out_col));
      end else begin
        want = awaited_px.pop_front();
        checked_count++;
        if (out_row !== want.row || out_col !== want.col || out_pixel !== want.pix)
          report($sformatf("got (%0d,%0d)=%0d, want (%0d,%0d)=%0d", out_row, out_col,
                           out_pixel, want.row, want.col, want.pix));
      end
    end
  end

  task automatic settle();
    wait (pending_ops.size() == 0 && !start && awaited_px.size() == 0);
    repeat (PIPE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      imrot_pkg::CFG_ROWS: img_rows = data[8:0];
      imrot_pkg::CFG_COLS: img_cols = data[8:0];
      imrot_pkg::CFG_COS:  cos_q = data;
      imrot_pkg::CFG_SIN:  sin_q = data;
      imrot_pkg::CFG_MODE: bilinear_on = data[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int rows, input int cols, input int c, input int s,
                              input bit mode);
    write_reg(imrot_pkg::CFG_ROWS, 16'(rows));
    write_reg(imrot_pkg::CFG_COLS, 16'(cols));
    write_reg(imrot_pkg::CFG_COS, 16'(c));
    write_reg(imrot_pkg::CFG_SIN, 16'(s));
    write_reg(imrot_pkg::CFG_MODE, 16'(mode));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    setting_count++;
  endtask

  task automatic push_op(input logic cmd, input int row, input int col, input int pix);
    pixel_op_t op;
    op = '{cmd, 8'(row), 8'(col), 8'(pix)};
    if (cmd == CMD_LOAD)
      loaded[{op.row, op.col}] = 1'b1;
    pending_ops = {pending_ops, op};
  endtask

  // The store is undefined until written, so every entry that a request will
  // read is loaded ahead of it if no earlier beat has loaded it.
  task automatic push_req(input int row, input int col);
    longint nr, nc, xf, yf, i, j, x, y, one;
    longint xs[4];
    longint ys[4];
    int n;
    one = longint'(1) <<< imrot_pkg::FRAC_BITS;
    map_point(8'(row), 8'(col), nr, nc, xf, yf);
    if (bilinear_on) begin
      i = xf >>> imrot_pkg::FRAC_BITS;
      j = yf >>> imrot_pkg::FRAC_BITS;
      xs[0] = i;     ys[0] = j;
      xs[1] = i;     ys[1] = j + 1;
      xs[2] = i + 1; ys[2] = j;
      xs[3] = i + 1; ys[3] = j + 1;
      n = 4;
    end else begin
      xs[0] = rne_shr(xf + one/2, imrot_pkg::FRAC_BITS);
      ys[0] = rne_shr(yf + one/2, imrot_pkg::FRAC_BITS);
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      x = xs[k];
      y = ys[k];
      if (x < 0) x = 0;
      else if (x >= nr) x = nr - 1;
      if (y < 0) y = 0;
      else if (y >= nc) y = nc - 1;
      if (!loaded[x*imrot_pkg::COLS_MAX + y])
        push_op(CMD_LOAD, int'(x), int'(y), $urandom_range(255));
    end
    push_op(CMD_REQ, row, col, $urandom_range(255));
  endtask

  task automatic random_ops(input int count);
    int r, c;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 20) begin
        push_op(CMD_LOAD, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end else begin
        // Mostly inside the image in use, sometimes anywhere.
        r = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(img_rows + 1) % 256;
        c = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(img_cols + 1) % 256;
        push_req(r, c);
      end
    end
  endtask

  initial begin
    int angle_cos[4] = '{16384, 11585, 0, -14189};
    int angle_sin[4] = '{0, 11585, 16384, 8192};
    int pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_req(0, 0);
    push_req(255, 255);
    push_req(0, 255);
    push_req(128, 128);
    push_op(CMD_LOAD, 255, 0, 255);
    push_req(255, 0);
    settle();
    set_geometry(256, 256, 16384, 0, 0);
    push_req(17, 200);
    push_req(255, 0);
    settle();
    set_geometry(0, 0, 11585, 11585, 1);
    push_req(0, 0);
    push_req(200, 3);
    settle();
    set_geometry(511, 300, -16384, 0, 1);
    push_req(10, 250);
    push_req(255, 255);
    settle();
    set_geometry(37, 200, 0, -16384, 0);
    push_req(36, 199);
    push_req(250, 250);
    settle();
    set_geometry(256, 256, -32768, 32767, 1);
    push_req(0, 255);
    push_req(255, 0);
    settle();
    set_geometry(1, 1, 32767, -32768, 0);
    write_reg(CFG_SPARE, 16'hffff);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    push_req(0, 0);
    push_req(255, 128);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      pick = $urandom_range(3);
      if (ph % 3 == 0)
        set_geometry($urandom_range(511), $urandom_range(511), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(1));
      else
        set_geometry($urandom_range(1, 64), $urandom_range(1, 256), angle_cos[pick],
                     angle_sin[pick], $urandom_range(1));
      idle_pct = (ph == 4) ? 0 : 37;
      random_ops((ph % 3 == 0) ? 20 : 35);
      if (ph == 7) begin
        wait (pending_ops.size() == 0);
        @(negedge clk);
        hold_off = 1'b1;
        wait (awaited_px.size() == 0);
        @(negedge clk);
        hold_off = 1'b0;
      end
      random_ops((ph % 3 == 0) ? 20 : 35);
      settle();
    end

    $display("tb: %0d loads and %0d rotated-pixel requests, %0d results checked",
             load_count, req_count, checked_count);
    $display("tb: %0d geometry and mode settings, both sampling modes", setting_count);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
